>>> design/jesa_pkg.sv
package jesa_pkg;

	localparam int TIME_W  = 20;
	localparam int TOTAL_W = 30;
	localparam int SUM_W   = 32;
	localparam int TERM_W  = 8;
	localparam int QUAL_W  = 7;
	localparam int SUB_W   = 2;
	localparam int BOUND_W = TERM_W + TIME_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TERM      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_QUAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_SUB  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CEIL      = 3'd6;

	// param_kind codes
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_SUB  = 2'd1;
	localparam logic [1:0] KIND_QUAL = 2'd2;

	// change_dir codes
	localparam logic [1:0] DIR_KEEP = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	// subsampling codes
	localparam logic [SUB_W-1:0] SUB_444 = 2'd0;
	localparam logic [SUB_W-1:0] SUB_422 = 2'd1;
	localparam logic [SUB_W-1:0] SUB_420 = 2'd2;

	localparam logic [TERM_W-1:0]   RST_TERM  = 8'd30;
	localparam logic [TIME_W-1:0]   RST_MIN   = 20'd31250;
	localparam logic [TIME_W-1:0]   RST_MAX   = 20'd35714;
	localparam logic [QUAL_W-1:0]   RST_QUAL  = 7'd80;
	localparam logic [SUB_W-1:0]    RST_SUB   = SUB_444;
	localparam logic [QUAL_W-1:0]   RST_FLOOR = 7'd1;
	localparam logic [QUAL_W-1:0]   RST_CEIL  = 7'd100;
	localparam logic [BOUND_W-1:0]  RST_HI    = BOUND_W'(30 * 35714);
	localparam logic [BOUND_W-1:0]  RST_LO    = BOUND_W'(30 * 31250);

	typedef struct packed {
		logic [TIME_W-1:0] wait_time_us;
		logic [TIME_W-1:0] sync_time_us;
		logic [TIME_W-1:0] view_time_us;
	} frame_t;

	typedef struct packed {
		logic [1:0]        param_kind;
		logic [1:0]        change_dir;
		logic              adjusted;
		logic [SUB_W-1:0]  subsampling_now;
		logic [QUAL_W-1:0] quality_now;
	} result_t;

	typedef struct packed {
		logic [TERM_W-1:0]  term;
		logic [QUAL_W-1:0]  floor_q;
		logic [QUAL_W-1:0]  ceil_q;
		logic [BOUND_W-1:0] hi_bound;
		logic [BOUND_W-1:0] lo_bound;
	} cfg_t;

	typedef struct packed {
		logic              ld_quality;
		logic              ld_subsampling;
		logic [QUAL_W-1:0] quality;
		logic [SUB_W-1:0]  subsampling;
	} init_ld_t;

endpackage

>>> design/jesa_in_if.sv
interface jesa_in_if import jesa_pkg::*; ();
	logic   valid;
	logic   ready;
	frame_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> design/jesa_out_if.sv
interface jesa_out_if import jesa_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> design/jpeg_encode_setting_adapter.sv
// Frame-timing driven JPEG setting adapter.
// frames:  one transfer per displayed frame carrying its wait, sync and view
//          times in microseconds.
// results: one transfer per frame with the decision for that frame and the
//          subsampling and quality in force after it.
// cfg_we/cfg_idx/cfg_data: register writes, index as listed in the register
//          map; write only while no frame is in flight.
// A frame passes the input register, then the result register, before its
// result is offered. Throughput: one frame per cycle while the result
// register is empty or results.ready is high; the running total, counter
// and settings update as a frame moves from the input register to the
// result register. A result waiting on a stalled receiver still lets one
// more frame enter the input register; frames.ready drops only when both
// registers are full and results.ready is low.
// Reset clears the running total and frame counter, loads subsampling 4:4:4
// and quality 80, and restores every register to its default.
module jpeg_encode_setting_adapter import jesa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	jesa_in_if.sink               frames,
	jesa_out_if.source            results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t     cfg;
	init_ld_t init_ld;
	result_t  res;

	logic    valid_s1;
	frame_t  frame_s1;
	logic    valid_s2;
	result_t res_s2;
	logic    advance;
	logic    step;

	assign advance      = !valid_s2 || results.ready;
	assign step         = valid_s1 && advance;
	assign frames.ready = !valid_s1 || advance;

	jesa_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg),
		.init_ld  (init_ld)
	);

	jesa_update u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.frame   (frame_s1),
		.cfg     (cfg),
		.init_ld (init_ld),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frames.ready) begin
			valid_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frames.ready && frames.valid) begin
			frame_s1 <= frames.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign results.valid = valid_s2;
	assign results.data  = res_s2;

endmodule

>>> design/jesa_cfg.sv
module jesa_cfg import jesa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output init_ld_t              init_ld
);

	logic [TERM_W-1:0]  term_q;
	logic [TIME_W-1:0]  min_q;
	logic [TIME_W-1:0]  max_q;
	logic [QUAL_W-1:0]  floor_q;
	logic [QUAL_W-1:0]  ceil_q;
	logic [BOUND_W-1:0] hi_q;
	logic [BOUND_W-1:0] lo_q;

	logic [TERM_W-1:0]  term_nxt;
	logic [TIME_W-1:0]  min_nxt;
	logic [TIME_W-1:0]  max_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q  <= RST_TERM;
			min_q   <= RST_MIN;
			max_q   <= RST_MAX;
			floor_q <= RST_FLOOR;
			ceil_q  <= RST_CEIL;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TERM:  term_q  <= cfg_data[TERM_W-1:0];
				REG_MIN:   min_q   <= cfg_data[TIME_W-1:0];
				REG_MAX:   max_q   <= cfg_data[TIME_W-1:0];
				REG_FLOOR: floor_q <= cfg_data[QUAL_W-1:0];
				REG_CEIL:  ceil_q  <= cfg_data[QUAL_W-1:0];
				default: ;
			endcase
		end
	end

	// register values as they stand after this edge, a write included
	always_comb begin
		term_nxt = (cfg_we && (cfg_idx == REG_TERM)) ? cfg_data[TERM_W-1:0] : term_q;
		min_nxt  = (cfg_we && (cfg_idx == REG_MIN)) ? cfg_data[TIME_W-1:0] : min_q;
		max_nxt  = (cfg_we && (cfg_idx == REG_MAX)) ? cfg_data[TIME_W-1:0] : max_q;
	end

	// window bounds, updated at the same edge as the registers they come from
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= RST_HI;
			lo_q <= RST_LO;
		end else begin
			hi_q <= BOUND_W'(term_nxt) * BOUND_W'(max_nxt);
			lo_q <= BOUND_W'(term_nxt) * BOUND_W'(min_nxt);
		end
	end

	always_comb begin
		init_ld.ld_quality     = cfg_we && (cfg_idx == REG_INIT_QUAL);
		init_ld.ld_subsampling = cfg_we && (cfg_idx == REG_INIT_SUB);
		init_ld.quality        = cfg_data[QUAL_W-1:0];
		// code three saturates to 4:2:0
		init_ld.subsampling    = (cfg_data[SUB_W-1:0] > SUB_420) ? SUB_420
		                                                         : cfg_data[SUB_W-1:0];
	end

	assign cfg.term     = term_q;
	assign cfg.floor_q  = floor_q;
	assign cfg.ceil_q   = ceil_q;
	assign cfg.hi_bound = hi_q;
	assign cfg.lo_bound = lo_q;

endmodule

>>> design/jesa_update.sv
module jesa_update import jesa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  frame_t   frame,
	input  cfg_t     cfg,
	input  init_ld_t init_ld,
	output result_t  res
);

	logic [TOTAL_W-1:0] total_q;
	logic [TERM_W-1:0]  count_q;
	logic [SUB_W-1:0]   sub_q;
	logic [QUAL_W-1:0]  qual_q;

	logic [SUM_W-1:0]   sum;
	logic [TOTAL_W-1:0] total_sat;
	logic [TERM_W-1:0]  count_inc;
	logic               win_end;
	logic               too_long;
	logic               too_short;
	logic [SUB_W-1:0]   sub_nxt;
	logic [QUAL_W-1:0]  qual_nxt;

	always_comb begin
		sum = SUM_W'(total_q) + SUM_W'(frame.wait_time_us) + SUM_W'(frame.sync_time_us)
		    + SUM_W'(frame.view_time_us);
		total_sat = (|sum[SUM_W-1:TOTAL_W]) ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
		count_inc = count_q + TERM_W'(1);
		win_end   = count_inc >= cfg.term;
		too_long  = total_sat > TOTAL_W'(cfg.hi_bound);
		too_short = total_sat < TOTAL_W'(cfg.lo_bound);

		sub_nxt        = sub_q;
		qual_nxt       = qual_q;
		res.param_kind = KIND_NONE;
		res.change_dir = DIR_KEEP;
		res.adjusted   = 1'b0;
		if (win_end) begin
			if (too_long) begin
				res.adjusted   = 1'b1;
				res.change_dir = DIR_DOWN;
				if (sub_q < SUB_420) begin
					res.param_kind = KIND_SUB;
					sub_nxt        = sub_q + SUB_W'(1);
				end else if (qual_q > cfg.floor_q) begin
					res.param_kind = KIND_QUAL;
					qual_nxt       = qual_q - QUAL_W'(1);
				end
			end else if (too_short) begin
				res.adjusted   = 1'b1;
				res.change_dir = DIR_UP;
				if (qual_q < cfg.ceil_q) begin
					res.param_kind = KIND_QUAL;
					qual_nxt       = qual_q + QUAL_W'(1);
				end else if (sub_q > SUB_444) begin
					res.param_kind = KIND_SUB;
					sub_nxt        = sub_q - SUB_W'(1);
				end
			end
		end
		res.subsampling_now = sub_nxt;
		res.quality_now     = qual_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= '0;
			sub_q   <= RST_SUB;
			qual_q  <= RST_QUAL;
		end else begin
			if (step) begin
				total_q <= win_end ? '0 : total_sat;
				count_q <= win_end ? '0 : count_inc;
				sub_q   <= sub_nxt;
				qual_q  <= qual_nxt;
			end
			// initial-value writes take effect at once
			if (init_ld.ld_quality) begin
				qual_q <= init_ld.quality;
			end
			if (init_ld.ld_subsampling) begin
				sub_q <= init_ld.subsampling;
			end
		end
	end

endmodule

>>> design/jesa_checker.sv
module jesa_checker import jesa_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_data
);

	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// frames taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two frames in flight");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without a frame");

	a_quiet_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.adjusted |->
			out_data.param_kind == KIND_NONE && out_data.change_dir == DIR_KEEP)
		else $error("change reported outside an adjustment");

endmodule

bind jpeg_encode_setting_adapter jesa_checker u_jesa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frames.valid),
	.in_ready  (frames.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);
